// ===== rtl/pbaf_pkg.sv =====
// ----------------------------------------------------------------------------
// pbaf_pkg: shared types and constants for the plastic bushing axis
// Widths, register map, yield codes, sequencer states, interface structs and sat32.
// ----------------------------------------------------------------------------
package pbaf_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CoefW = 31;
  localparam int unsigned FracW = 16;
  localparam int unsigned AluW  = 64;
  localparam int unsigned QuotW = CoefW + FracW;
  localparam int unsigned SumW  = AluW - FracW;
  localparam int unsigned CntW  = 6;
  localparam int unsigned AddrW = 4;

  localparam logic [CntW-1:0] MulSteps = CntW'(CoefW);
  localparam logic [CntW-1:0] DivSteps = CntW'(QuotW);

  // register map, index is paddr[3:2]
  localparam logic [1:0] RegStiff = 2'd0;
  localparam logic [1:0] RegDamp  = 2'd1;
  localparam logic [1:0] RegYield = 2'd2;

  localparam logic [CoefW-1:0] StiffRst = 31'd65536;
  localparam logic [CoefW-1:0] DampRst  = 31'd0;
  localparam logic [CoefW-1:0] YieldRst = 31'h7fff_ffff;

  localparam logic [1:0] YsElastic = 2'd0;
  localparam logic [1:0] YsCapPos  = 2'd1;
  localparam logic [1:0] YsCapNeg  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL_K,
    ST_MID,
    ST_MUL_D,
    ST_SUM,
    ST_CMP,
    ST_DIV,
    ST_FIX,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [CoefW-1:0] stiffness;
    logic [CoefW-1:0] damping;
    logic [CoefW-1:0] yield_force;
  } cfg_t;

  typedef struct packed {
    logic [AluW-1:0] a;
    logic [AluW-1:0] b;
    logic            sub;
  } alu_req_t;

  function automatic logic [DataW-1:0] sat32(input logic [AluW-1:0] x);
    logic fits;
    fits = (&x[AluW-1:DataW-1]) || (~|x[AluW-1:DataW-1]);
    if (fits) begin
      return x[DataW-1:0];
    end else if (x[AluW-1]) begin
      return {1'b1, {(DataW-1){1'b0}}};
    end else begin
      return {1'b0, {(DataW-1){1'b1}}};
    end
  endfunction

endpackage

// ===== rtl/pbaf_in_if.sv =====
// ----------------------------------------------------------------------------
// pbaf_in_if: input channel of the plastic bushing axis
// Valid/ready beat carrying relative position and velocity.
// ----------------------------------------------------------------------------
interface pbaf_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pbaf_pkg::DataW-1:0]   rel_position;
  logic signed [pbaf_pkg::DataW-1:0]   rel_velocity;

  modport source (output valid, output rel_position, output rel_velocity, input ready);
  modport sink   (input valid, input rel_position, input rel_velocity, output ready);
endinterface

// ===== rtl/pbaf_out_if.sv =====
// ----------------------------------------------------------------------------
// pbaf_out_if: result channel of the plastic bushing axis
// Valid/ready beat carrying force, yield state and plastic offset.
// ----------------------------------------------------------------------------
interface pbaf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pbaf_pkg::DataW-1:0]   axis_force;
  logic [1:0]                          yield_state;
  logic signed [pbaf_pkg::DataW-1:0]   plastic_offset_out;

  modport source (output valid, output axis_force, output yield_state,
                  output plastic_offset_out, input ready);
  modport sink   (input valid, input axis_force, input yield_state,
                  input plastic_offset_out, output ready);
endinterface

// ===== rtl/plastic_bushing_axis_force_top.sv =====
// ----------------------------------------------------------------------------
// plastic_bushing_axis_force_top: one axis of an elastic-plastic bushing
// Spring-damper force with yield cap and plastic offset, Q16.16 throughout.
// Elastic beats skip the divide and offset steps; capped beats run them.
// The single shared 64-bit adder takes 31 steps per product and 47 per divide.
// A new beat is accepted only in idle, after the last result loads; out stalls hold it.
// Reset (rst_n low, synchronous): registers to defaults, offset zero, idle.
// ----------------------------------------------------------------------------
module plastic_bushing_axis_force_top (
  input  logic                         clk,
  input  logic                         rst_n,
  pbaf_in_if.sink                      in_ch,
  pbaf_out_if.source                   out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [pbaf_pkg::AddrW-1:0]   cfg_paddr,
  input  logic [pbaf_pkg::DataW-1:0]   cfg_pwdata,
  output logic [pbaf_pkg::DataW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);

  pbaf_pkg::cfg_t             cfg;
  pbaf_pkg::alu_req_t         alu_req;
  logic [pbaf_pkg::AluW-1:0]  alu_sum;

  pbaf_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  pbaf_alu u_alu (
    .req (alu_req),
    .sum (alu_sum)
  );

  pbaf_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .alu_req (alu_req),
    .alu_sum (alu_sum)
  );

endmodule

// ===== rtl/pbaf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pbaf_cfg_regs: APB register file
// Stiffness, damping and yield force registers with readback.
// ----------------------------------------------------------------------------
module pbaf_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pbaf_pkg::AddrW-1:0]   paddr,
  input  logic [pbaf_pkg::DataW-1:0]   pwdata,
  output logic [pbaf_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  output pbaf_pkg::cfg_t               cfg
);

  pbaf_pkg::cfg_t cfg_r;
  pbaf_pkg::cfg_t cfg_nxt;
  logic [1:0]     idx;
  logic           wr_en;

  assign idx    = paddr[pbaf_pkg::AddrW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        pbaf_pkg::RegStiff: cfg_nxt.stiffness   = pwdata[pbaf_pkg::CoefW-1:0];
        pbaf_pkg::RegDamp:  cfg_nxt.damping     = pwdata[pbaf_pkg::CoefW-1:0];
        pbaf_pkg::RegYield: cfg_nxt.yield_force = pwdata[pbaf_pkg::CoefW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      pbaf_pkg::RegStiff: prdata = {1'b0, cfg_r.stiffness};
      pbaf_pkg::RegDamp:  prdata = {1'b0, cfg_r.damping};
      pbaf_pkg::RegYield: prdata = {1'b0, cfg_r.yield_force};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stiffness   <= pbaf_pkg::StiffRst;
      cfg_r.damping     <= pbaf_pkg::DampRst;
      cfg_r.yield_force <= pbaf_pkg::YieldRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/pbaf_alu.sv =====
// ----------------------------------------------------------------------------
// pbaf_alu: shared 64-bit adder/subtractor
// Serves the difference, shift-add products, sum, restoring divide and offset.
// ----------------------------------------------------------------------------
module pbaf_alu (
  input  pbaf_pkg::alu_req_t            req,
  output logic [pbaf_pkg::AluW-1:0]     sum
);

  logic [pbaf_pkg::AluW-1:0] b_inv;

  assign b_inv = req.b ^ {pbaf_pkg::AluW{req.sub}};
  assign sum   = req.a + b_inv + {{(pbaf_pkg::AluW-1){1'b0}}, req.sub};

endmodule

// ===== rtl/pbaf_core.sv =====
// ----------------------------------------------------------------------------
// pbaf_core: sequencer and datapath registers
// Drives the shared adder through difference, two products, sum, divide and offset;
// the yield cap is applied by comparison.
module pbaf_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pbaf_pkg::cfg_t              cfg,
  pbaf_in_if.sink                     in_ch,
  pbaf_out_if.source                  out_ch,
  output pbaf_pkg::alu_req_t          alu_req,
  input  logic [pbaf_pkg::AluW-1:0]   alu_sum
);

  localparam int unsigned AW = pbaf_pkg::AluW;
  localparam int unsigned DW = pbaf_pkg::DataW;
  localparam int unsigned CW = pbaf_pkg::CoefW;
  localparam int unsigned FW = pbaf_pkg::FracW;
  localparam int unsigned QW = pbaf_pkg::QuotW;
  localparam int unsigned SW = pbaf_pkg::SumW;

  pbaf_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]            acc_r, acc_nxt;
  logic [AW-1:0]            opa_r, opa_nxt;
  logic [CW-1:0]            opb_r, opb_nxt;
  logic [pbaf_pkg::CntW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0]            sum1_r, sum1_nxt;
  logic [DW-1:0]            pos_r, pos_nxt;
  logic [DW-1:0]            vel_r, vel_nxt;
  logic [1:0]               st_r, st_nxt;
  logic [DW-1:0]            force_r, force_nxt;
  logic [DW-1:0]            off_r, off_nxt;
  logic                     ov_r, ov_nxt;
  logic [DW-1:0]            of_r, of_nxt;
  logic [1:0]               oys_r, oys_nxt;
  logic [DW-1:0]            ooff_r, ooff_nxt;

  logic [CW-1:0]            k_eff;
  logic [AW-1:0]            yield_w;
  logic [AW-1:0]            div_shift;
  logic [DW-1:0]            new_off;
  logic                     load_out;

  // zero stiffness acts as one lsb
  assign k_eff   = (cfg.stiffness == '0) ? {{(CW-1){1'b0}}, 1'b1} : cfg.stiffness;
  assign yield_w = {{(AW-CW){1'b0}}, cfg.yield_force};
  assign div_shift = {acc_r[AW-2:0], opa_r[QW-1]};
  assign load_out  = (state_r == pbaf_pkg::ST_DONE) && (!ov_r || out_ch.ready);
  assign new_off   = (st_r == pbaf_pkg::YsElastic) ? off_r : pbaf_pkg::sat32(acc_r);

  assign in_ch.ready               = (state_r == pbaf_pkg::ST_IDLE);
  assign out_ch.valid              = ov_r;
  assign out_ch.axis_force         = of_r;
  assign out_ch.yield_state        = oys_r;
  assign out_ch.plastic_offset_out = ooff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pbaf_pkg::ST_IDLE;
      ov_r    <= 1'b0;
      off_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      off_r   <= off_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    opa_r   <= opa_nxt;
    opb_r   <= opb_nxt;
    cnt_r   <= cnt_nxt;
    sum1_r  <= sum1_nxt;
    pos_r   <= pos_nxt;
    vel_r   <= vel_nxt;
    st_r    <= st_nxt;
    force_r <= force_nxt;
    of_r    <= of_nxt;
    oys_r   <= oys_nxt;
    ooff_r  <= ooff_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    opa_nxt   = opa_r;
    opb_nxt   = opb_r;
    cnt_nxt   = cnt_r;
    sum1_nxt  = sum1_r;
    pos_nxt   = pos_r;
    vel_nxt   = vel_r;
    st_nxt    = st_r;
    force_nxt = force_r;
    off_nxt   = off_r;
    ov_nxt    = ov_r && !out_ch.ready;
    of_nxt    = of_r;
    oys_nxt   = oys_r;
    ooff_nxt  = ooff_r;

    alu_req.a   = acc_r;
    alu_req.b   = opa_r;
    alu_req.sub = 1'b0;

    unique case (state_r)
      pbaf_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          pos_nxt   = in_ch.rel_position;
          vel_nxt   = in_ch.rel_velocity;
          state_nxt = pbaf_pkg::ST_DIFF;
        end
      end

      pbaf_pkg::ST_DIFF: begin
        alu_req.a   = {{(AW-DW){pos_r[DW-1]}}, pos_r};
        alu_req.b   = {{(AW-DW){off_r[DW-1]}}, off_r};
        alu_req.sub = 1'b1;
        opa_nxt     = alu_sum;
        acc_nxt     = '0;
        opb_nxt     = k_eff;
        cnt_nxt     = pbaf_pkg::MulSteps;
        state_nxt   = pbaf_pkg::ST_MUL_K;
      end

      pbaf_pkg::ST_MUL_K, pbaf_pkg::ST_MUL_D: begin
        // shift-add over the unsigned coefficient bits
        if (opb_r[0]) begin
          acc_nxt = alu_sum;
        end
        opa_nxt = {opa_r[AW-2:0], 1'b0};
        opb_nxt = {1'b0, opb_r[CW-1:1]};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == {{(pbaf_pkg::CntW-1){1'b0}}, 1'b1}) begin
          state_nxt = (state_r == pbaf_pkg::ST_MUL_K) ? pbaf_pkg::ST_MID : pbaf_pkg::ST_SUM;
        end
      end

      pbaf_pkg::ST_MID: begin
        // floor to q16.16 is the top bits of the product
        sum1_nxt  = acc_r[AW-1:FW];
        acc_nxt   = '0;
        opa_nxt   = {{(AW-DW){vel_r[DW-1]}}, vel_r};
        opb_nxt   = cfg.damping;
        cnt_nxt   = pbaf_pkg::MulSteps;
        state_nxt = pbaf_pkg::ST_MUL_D;
      end

      pbaf_pkg::ST_SUM: begin
        alu_req.a = {{FW{acc_r[AW-1]}}, acc_r[AW-1:FW]};
        alu_req.b = {{FW{sum1_r[SW-1]}}, sum1_r};
        acc_nxt   = alu_sum;
        state_nxt = pbaf_pkg::ST_CMP;
      end

      pbaf_pkg::ST_CMP: begin
        if ($signed(acc_r) > $signed(yield_w)) begin
          st_nxt    = pbaf_pkg::YsCapPos;
          force_nxt = {1'b0, cfg.yield_force};
        end else if ($signed(acc_r) < -$signed(yield_w)) begin
          st_nxt    = pbaf_pkg::YsCapNeg;
          force_nxt = -{1'b0, cfg.yield_force};
        end else begin
          st_nxt    = pbaf_pkg::YsElastic;
          force_nxt = acc_r[DW-1:0];
        end
        // dividend is |capped| * 2^16, magnitude divide
        acc_nxt   = '0;
        opa_nxt   = {{(AW-QW){1'b0}}, cfg.yield_force, {FW{1'b0}}};
        cnt_nxt   = pbaf_pkg::DivSteps;
        state_nxt = (st_nxt == pbaf_pkg::YsElastic) ? pbaf_pkg::ST_DONE : pbaf_pkg::ST_DIV;
      end

      pbaf_pkg::ST_DIV: begin
        // restoring divide, one quotient bit per beat of the adder
        alu_req.a   = div_shift;
        alu_req.b   = {{(AW-CW){1'b0}}, k_eff};
        alu_req.sub = 1'b1;
        if (!alu_sum[AW-1]) begin
          acc_nxt = alu_sum;
          opa_nxt = {opa_r[AW-2:0], 1'b1};
        end else begin
          acc_nxt = div_shift;
          opa_nxt = {opa_r[AW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == {{(pbaf_pkg::CntW-1){1'b0}}, 1'b1}) begin
          state_nxt = pbaf_pkg::ST_FIX;
        end
      end

      pbaf_pkg::ST_FIX: begin
        alu_req.a   = {{(AW-DW){pos_r[DW-1]}}, pos_r};
        alu_req.b   = {{(AW-QW){1'b0}}, opa_r[QW-1:0]};
        alu_req.sub = (st_r == pbaf_pkg::YsCapPos);
        acc_nxt     = alu_sum;
        state_nxt   = pbaf_pkg::ST_DONE;
      end

      pbaf_pkg::ST_DONE: begin
        if (load_out) begin
          ov_nxt    = 1'b1;
          of_nxt    = force_r;
          oys_nxt   = st_r;
          ooff_nxt  = new_off;
          off_nxt   = new_off;
          state_nxt = pbaf_pkg::ST_IDLE;
        end
      end

      default: state_nxt = pbaf_pkg::ST_IDLE;
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == pbaf_pkg::ST_DIFF))
    else $error("accepted beat did not start the sequence");

  a_pos_cap_force: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && st_r == pbaf_pkg::YsCapPos)
      |=> (ov_r && of_r == {1'b0, $past(cfg.yield_force)}))
    else $error("positive cap force differs from yield");

  a_elastic_keeps_off: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && st_r == pbaf_pkg::YsElastic) |=> (off_r == $past(off_r)))
    else $error("elastic step moved the plastic offset");

  a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pbaf_pkg::ST_MUL_K || state_r == pbaf_pkg::ST_MUL_D ||
     state_r == pbaf_pkg::ST_DIV) |-> (cnt_r != '0))
    else $error("step counter ran out inside an iteration");

endmodule
